>>> rtl/ffha_pkg.sv
// Shared constants for the first-fit heap allocator: pool geometry defaults,
// command codes and result status codes. No dependencies.
package ffha_pkg;

    localparam int POOL_BYTES    = 8192;
    localparam int GRANULE_BYTES = 8;
    localparam int HEADER_BYTES  = 24;

    localparam int REQ_W    = 16;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LARGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OOM      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BOUNDS   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTBLOCK = 3'd6;

endpackage

>>> rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing: block headers kept in one
// synchronous memory indexed by header byte offset. Depends on ffha_pkg.
//
// Usage: one request beat on the in channel (command, request_size,
// data_offset) yields one result beat on the out channel (status,
// granted_offset). Both channels use valid/ready.
// An allocate rounds its size with a mask in the accept cycle, then walks
// the block list from offset 0 with a memory read state and an evaluate
// state per block; a split adds a write state. A free walks the list the
// same way up to its block, then, unless it is the last block, reads the
// following block for merging. With the default pool there are at most
// 256 blocks, and the walk, one header read at a time, sets how long a
// request takes. Size-zero, too-large, out-of-bounds and
// below-first-header requests answer without a walk. The next beat can be
// accepted in the cycle in which the result is first shown. After reset
// the block writes the initial free header at offset 0 in its init state
// and then accepts requests. One request is in work at a time; in_ready
// is high only while idle. A finished result is held in the output
// register while the receiver stalls, and the block waits.
module first_fit_heap_allocator_top #(
    parameter int POOL_BYTES    = ffha_pkg::POOL_BYTES,
    parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [ffha_pkg::REQ_W-1:0]    request_size,
    input  logic [ffha_pkg::REQ_W-1:0]    data_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffha_pkg::STATUS_W-1:0] status,
    output logic [ffha_pkg::GRANT_W-1:0]  granted_offset
);

    localparam int AW  = $clog2(POOL_BYTES + 1);
    localparam int IW  = $clog2(POOL_BYTES);
    localparam int SW  = IW;
    localparam int NW  = ffha_pkg::REQ_W + 1;
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] POOL = AW'(POOL_BYTES);
    localparam logic [NW-1:0] MAXREQ = NW'(POOL_BYTES - HEADER_BYTES);
    localparam logic [NW-1:0] GMASK  = ~NW'(GRANULE_BYTES - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_EV, S_RDN, S_EVN, S_SPLIT, S_DONE
    } state_t;

    state_t              state_reg;
    logic                cmd_reg;
    logic [AW-1:0]       aligned_reg;
    logic [AW-1:0]       target_reg;
    logic [AW-1:0]       cur_reg;
    logic [AW-1:0]       cur_size_reg;
    logic [AW-1:0]       prev_reg;
    logic [AW-1:0]       prev_size_reg;
    logic                prev_free_reg;
    logic [AW-1:0]       split_addr_reg;
    logic [AW-1:0]       split_size_reg;
    logic [ffha_pkg::STATUS_W-1:0] st_reg;
    logic [ffha_pkg::GRANT_W-1:0]  gr_reg;
    logic                out_valid_reg;
    logic [ffha_pkg::STATUS_W-1:0] status_reg;
    logic [ffha_pkg::GRANT_W-1:0]  granted_reg;

    logic [SW:0]   mem [POOL_BYTES];
    logic [SW:0]   rdata_reg;
    logic [IW-1:0] rd_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW:0]   mem_wdata;

    logic [AW-1:0] rd_size;
    logic          rd_free;
    logic [AW-1:0] nxt;
    logic          nx_free;
    logic [AW-1:0] m_size;
    logic [AW-1:0] m_start;

    assign rd_addr = cur_reg[IW-1:0];
    assign rd_size = AW'(rdata_reg[SW-1:0]);
    assign rd_free = rdata_reg[SW];
    assign nxt     = cur_reg + HDR + rd_size;
    assign nx_free = (state_reg == S_EVN) && rd_free;

    always_comb
    begin
        m_size  = ((state_reg == S_EV) ? rd_size : cur_size_reg)
                  + (nx_free ? (HDR + rd_size) : '0);
        m_start = cur_reg;
        if (prev_free_reg)
        begin
            m_size  = m_size + prev_size_reg + HDR;
            m_start = prev_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = {1'b0, rd_size[SW-1:0]};
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {1'b1, SW'(POOL_BYTES - HEADER_BYTES)};
            end
            S_EV:
            begin
                if (cmd_reg == ffha_pkg::CMD_ALLOC && rd_free && rd_size >= aligned_reg)
                begin
                    mem_we = 1'b1;
                    if (rd_size > aligned_reg + HDR)
                        mem_wdata = {1'b0, aligned_reg[SW-1:0]};
                end
                else if (cmd_reg == ffha_pkg::CMD_FREE && cur_reg == target_reg
                         && !rd_free && nxt >= POOL)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = m_start;
                    mem_wdata = {1'b1, m_size[SW-1:0]};
                end
            end
            S_EVN:
            begin
                mem_we    = 1'b1;
                mem_waddr = m_start;
                mem_wdata = {1'b1, m_size[SW-1:0]};
            end
            S_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = split_addr_reg;
                mem_wdata = {1'b1, split_size_reg[SW-1:0]};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr[IW-1:0]] <= mem_wdata;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= command;
                        gr_reg        <= '0;
                        st_reg        <= ffha_pkg::ST_OK;
                        cur_reg       <= '0;
                        prev_free_reg <= 1'b0;
                        aligned_reg   <= AW'((NW'(request_size) + NW'(GRANULE_BYTES - 1))
                                             & GMASK);
                        target_reg    <= AW'(data_offset) - HDR;
                        if (command == ffha_pkg::CMD_ALLOC)
                        begin
                            if (request_size == '0)
                            begin
                                st_reg    <= ffha_pkg::ST_ZERO;
                                state_reg <= S_DONE;
                            end
                            else if (NW'(request_size) > MAXREQ)
                            begin
                                st_reg    <= ffha_pkg::ST_LARGE;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_RD;
                        end
                        else
                        begin
                            if ({1'b0, data_offset} >= NW'(POOL_BYTES))
                            begin
                                st_reg    <= ffha_pkg::ST_BOUNDS;
                                state_reg <= S_DONE;
                            end
                            else if (AW'(data_offset) < HDR)
                            begin
                                st_reg    <= ffha_pkg::ST_NOTBLOCK;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (cmd_reg == ffha_pkg::CMD_ALLOC)
                    begin
                        if (rd_free && rd_size >= aligned_reg)
                        begin
                            gr_reg         <= ffha_pkg::GRANT_W'(cur_reg + HDR);
                            split_addr_reg <= cur_reg + HDR + aligned_reg;
                            split_size_reg <= rd_size - aligned_reg - HDR;
                            if (rd_size > aligned_reg + HDR)
                                state_reg <= S_SPLIT;
                            else
                                state_reg <= S_DONE;
                        end
                        else if (nxt >= POOL)
                        begin
                            st_reg    <= ffha_pkg::ST_OOM;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg   <= nxt;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (cur_reg == target_reg)
                        begin
                            if (rd_free)
                            begin
                                st_reg    <= ffha_pkg::ST_DOUBLE;
                                state_reg <= S_DONE;
                            end
                            else if (nxt >= POOL)
                                state_reg <= S_DONE;
                            else
                            begin
                                split_addr_reg <= cur_reg;
                                cur_reg   <= nxt;
                                state_reg <= S_RDN;
                            end
                            if (!rd_free)
                                cur_size_reg <= rd_size;
                        end
                        else if (cur_reg > target_reg || nxt >= POOL)
                        begin
                            st_reg    <= ffha_pkg::ST_NOTBLOCK;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            prev_reg      <= cur_reg;
                            prev_size_reg <= rd_size;
                            prev_free_reg <= rd_free;
                            cur_reg       <= nxt;
                            state_reg     <= S_RD;
                        end
                    end
                end
                S_RDN:
                begin
                    cur_reg   <= split_addr_reg;
                    state_reg <= S_EVN;
                end
                S_EVN:
                begin
                    state_reg <= S_DONE;
                end
                S_SPLIT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        granted_reg   <= gr_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;

endmodule

>>> sim/first_fit_heap_allocator_top_tb.sv
// Testbench for first_fit_heap_allocator_top: random and directed allocate/free beats,
// checked against an in-bench block-list predictor held in a scoreboard class.
// Depends on ffha_pkg and the first_fit_heap_allocator_top RTL.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_tb;

    localparam int POOL_B  = ffha_pkg::POOL_BYTES;
    localparam int HDR_B   = ffha_pkg::HEADER_BYTES;
    localparam int GRAN_B  = ffha_pkg::GRANULE_BYTES;
    localparam int MAX_BLK = POOL_B / HDR_B + 2;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [ffha_pkg::STATUS_W-1:0] st;
        logic [ffha_pkg::GRANT_W-1:0]  grant;
    } heap_result_t;

    class heap_scoreboard;
        int unsigned   blk_base [MAX_BLK];
        int unsigned   blk_len  [MAX_BLK];
        bit            blk_idle [MAX_BLK];
        int unsigned   nblk;
        heap_result_t  pending_q[$];
        int            errors;
        int            n_grant;
        int            n_release;
        int            n_reject;

        function new();
            nblk = 1;
            blk_base[0] = 0;
            blk_len[0] = POOL_B - HDR_B;
            blk_idle[0] = 1;
        endfunction

        function logic [ffha_pkg::STATUS_W-1:0] take(int unsigned sz, output int unsigned g);
            int unsigned al;
            g = 0;
            if (sz == 0) return ffha_pkg::ST_ZERO;
            if (sz > POOL_B - HDR_B) return ffha_pkg::ST_LARGE;
            al = (sz + GRAN_B - 1) / GRAN_B * GRAN_B;
            for (int i = 0; i < nblk; i++)
            begin
                if (blk_idle[i] && blk_len[i] >= al)
                begin
                    if (blk_len[i] > al + HDR_B && nblk < MAX_BLK)
                    begin
                        for (int j = nblk; j > i + 1; j--)
                        begin
                            blk_base[j] = blk_base[j-1];
                            blk_len[j]  = blk_len[j-1];
                            blk_idle[j] = blk_idle[j-1];
                        end
                        blk_base[i+1] = blk_base[i] + HDR_B + al;
                        blk_len[i+1]  = blk_len[i] - al - HDR_B;
                        blk_idle[i+1] = 1;
                        blk_len[i]    = al;
                        nblk++;
                    end
                    blk_idle[i] = 0;
                    g = blk_base[i] + HDR_B;
                    return ffha_pkg::ST_OK;
                end
            end
            return ffha_pkg::ST_OOM;
        endfunction

        function logic [ffha_pkg::STATUS_W-1:0] give_back(int unsigned off);
            int unsigned i;
            if (off >= POOL_B) return ffha_pkg::ST_BOUNDS;
            for (int k = 0; k < nblk; k++)
            begin
                if (blk_base[k] + HDR_B == off)
                begin
                    if (blk_idle[k]) return ffha_pkg::ST_DOUBLE;
                    blk_idle[k] = 1;
                    i = 0;
                    while (i + 1 < nblk)
                    begin
                        if (blk_idle[i] && blk_idle[i+1])
                        begin
                            blk_len[i] += HDR_B + blk_len[i+1];
                            for (int j = i + 1; j + 1 < nblk; j++)
                            begin
                                blk_base[j] = blk_base[j+1];
                                blk_len[j]  = blk_len[j+1];
                                blk_idle[j] = blk_idle[j+1];
                            end
                            nblk--;
                        end
                        else
                            i++;
                    end
                    return ffha_pkg::ST_OK;
                end
            end
            return ffha_pkg::ST_NOTBLOCK;
        endfunction

        function void note(logic cmd, logic [ffha_pkg::REQ_W-1:0] sz,
                           logic [ffha_pkg::REQ_W-1:0] off);
            heap_result_t r;
            int unsigned g;
            g = 0;
            if (cmd == ffha_pkg::CMD_ALLOC) r.st = take(32'(sz), g);
            else r.st = give_back(32'(off));
            r.grant = g[ffha_pkg::GRANT_W-1:0];
            if (r.st != ffha_pkg::ST_OK) n_reject++;
            else if (cmd == ffha_pkg::CMD_ALLOC) n_grant++;
            else n_release++;
            pending_q.push_back(r);
        endfunction

        function void check(logic [ffha_pkg::STATUS_W-1:0] st,
                            logic [ffha_pkg::GRANT_W-1:0] grant);
            heap_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d granted_offset=%0d",
                         $time, st, grant);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
            if (grant !== e.grant)
            begin
                $display("%0t: granted_offset expected %0d actual %0d",
                         $time, e.grant, grant);
                errors++;
            end
        endfunction

        // data start of a random block in the wanted state, or -1
        function int pick_block(bit want_idle);
            int idx[$];
            for (int i = 0; i < nblk; i++)
                if (blk_idle[i] == want_idle) idx.push_back(i);
            if (idx.size() == 0) return -1;
            return blk_base[idx[$urandom_range(idx.size() - 1)]] + HDR_B;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          command;
    logic [ffha_pkg::REQ_W-1:0]    request_size;
    logic [ffha_pkg::REQ_W-1:0]    data_offset;
    logic                          out_valid;
    logic                          out_ready;
    logic [ffha_pkg::STATUS_W-1:0] status;
    logic [ffha_pkg::GRANT_W-1:0]  granted_offset;

    heap_scoreboard sb;
    int tx_idle;
    int rx_stall;
    int hold_cycles;
    int cycles;
    int n_beats;

    first_fit_heap_allocator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .request_size   (request_size),
        .data_offset    (data_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // called just after a falling edge; returns just after a falling edge, once the beat has been accepted
    task automatic send(logic cmd, logic [ffha_pkg::REQ_W-1:0] sz,
                        logic [ffha_pkg::REQ_W-1:0] off);
        int gap;
        if (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            gap = $urandom_range(1, 6);
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        request_size = sz;
        data_offset = off;
        in_valid = 1;
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        sb.note(cmd, sz, off);
        n_beats++;
        @(negedge clk);
    endtask

    task automatic send_random();
        int r;
        int o;
        r = $urandom_range(99);
        if (r < 45)
        begin
            r = $urandom_range(99);
            if (r < 80) send(ffha_pkg::CMD_ALLOC, 16'($urandom_range(1, 200)), 16'($urandom));
            else if (r < 95)
                send(ffha_pkg::CMD_ALLOC, 16'($urandom_range(1, 2048)), 16'($urandom));
            else send(ffha_pkg::CMD_ALLOC, 16'($urandom), 16'($urandom));
        end
        else if (r < 82)
        begin
            o = sb.pick_block(0);
            if (o < 0) send(ffha_pkg::CMD_ALLOC, 16'($urandom_range(1, 300)), 16'($urandom));
            else send(ffha_pkg::CMD_FREE, 16'($urandom), 16'(o));
        end
        else if (r < 89)
        begin
            o = sb.pick_block(1);
            send(ffha_pkg::CMD_FREE, 16'($urandom),
                 16'((o < 0) ? $urandom_range(0, POOL_B - 1) : o));
        end
        else if (r < 95)
            send(ffha_pkg::CMD_FREE, 16'($urandom), 16'($urandom_range(0, POOL_B - 1)));
        else
            send(ffha_pkg::CMD_FREE, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 0;
                hold_cycles--;
            end
            else
                out_ready = (rx_stall == 0) || ($urandom_range(99) >= rx_stall);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check(status, granted_offset);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending_q.size());
            $display("** first_fit_heap_allocator_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int a0;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        command = ffha_pkg::CMD_ALLOC;
        request_size = 0;
        data_offset = 0;
        tx_idle = 0;
        rx_stall = 0;
        hold_cycles = 0;
        cycles = 0;
        n_beats = 0;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: edge sizes, whole-pool grant, bad frees
        send(ffha_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
        send(ffha_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'(POOL_B - HDR_B + 1), 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'(POOL_B - HDR_B), 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
        send(ffha_pkg::CMD_FREE, 16'hFFFF, 16'(HDR_B));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(HDR_B));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(POOL_B));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'hFFFF);
        send(ffha_pkg::CMD_FREE, 16'd0, 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd8, 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd9, 16'd0);
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(HDR_B + 4));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(2 * HDR_B + 8 - 2));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(2 * HDR_B + 8));
        send(ffha_pkg::CMD_ALLOC, 16'd8, 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(HDR_B));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(2 * HDR_B + 8));
        send(ffha_pkg::CMD_FREE, 16'd0, 16'(3 * HDR_B + 16));
        a0 = sb.pick_block(0);
        if (a0 >= 0) send(ffha_pkg::CMD_FREE, 16'd0, 16'(a0));
        send(ffha_pkg::CMD_ALLOC, 16'(POOL_B - HDR_B - 8), 16'd0);
        send(ffha_pkg::CMD_ALLOC, 16'd40, 16'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle = 0;  rx_stall = 0;  end
                1: begin tx_idle = 65; rx_stall = 0;  end
                2: begin tx_idle = 0;  rx_stall = 65; end
                default: begin tx_idle = 16; rx_stall = 16; end
            endcase
            for (int k = 0; k < 107; k++)
            begin
                if (ph == 1 && k == 50) hold_cycles = 600;
                if (ph == 3 && k == 50)
                begin
                    in_valid = 0;
                    while (sb.pending_q.size() != 0) @(negedge clk);
                    repeat (20) @(negedge clk);
                end
                send_random();
            end
        end
        in_valid = 0;

        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);

        $display("%0d beats sent: %0d grants, %0d releases, %0d rejects",
                 n_beats, sb.n_grant, sb.n_release, sb.n_reject);
        $display("idle/stall mixes 0/0, 65/0, 0/65, 16/16 with a long output hold-off");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("** first_fit_heap_allocator_top: PASSED **");
        else
            $display("** first_fit_heap_allocator_top: FAILED **");
        $finish;
    end

endmodule
